>>> rtl/cfr_pkg.sv
`default_nettype none
package cfr_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LEN_W    = 32;
  localparam int unsigned CHUNK_W  = 16;
  localparam int unsigned CRC_W    = 16;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned SLOTS    = 3;

  localparam logic [CRC_W-1:0]   CRC_POLY        = 16'h1021;
  localparam logic [CHUNK_W-1:0] MAX_CHUNK_RESET = 16'd8192;

  // result kinds
  localparam logic [KIND_W-1:0] K_DATA   = 2'd0;
  localparam logic [KIND_W-1:0] K_REPLY  = 2'd1;
  localparam logic [KIND_W-1:0] K_SEEK   = 2'd2;
  localparam logic [KIND_W-1:0] K_STATUS = 2'd3;

  // transfer status codes
  localparam logic [STATUS_W-1:0] ST_RUNNING   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_COMPLETED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ABORTED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_TOO_LONG  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_CMD   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_CRC_ERR   = 3'd5;

  // protocol characters
  localparam logic [BYTE_W-1:0] CH_CHUNK = 8'h63;  // 'c'
  localparam logic [BYTE_W-1:0] CH_SEEK  = 8'h73;  // 's'
  localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;  // '-'
  localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [BYTE_W-1:0] CH_DONE  = 8'h5E;  // '^'

  // configuration register indexes
  localparam logic REG_MAX_CHUNK = 1'b0;

  typedef enum logic [2:0] {
    PH_LEN  = 3'd0,
    PH_CMD  = 3'd1,
    PH_CLEN = 3'd2,
    PH_CCRC = 3'd3,
    PH_DATA = 3'd4,
    PH_SEEK = 3'd5
  } phase_t;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [BYTE_W-1:0]   data;
    logic [LEN_W-1:0]    seek;
    logic [STATUS_W-1:0] status;
  } result_t;

  function automatic result_t mk_result(input logic [KIND_W-1:0] kind,
                                        input logic [BYTE_W-1:0] data,
                                        input logic [LEN_W-1:0] seek,
                                        input logic [STATUS_W-1:0] status);
    result_t r;
    r.kind   = kind;
    r.data   = data;
    r.seek   = seek;
    r.status = status;
    return r;
  endfunction

  // crc-16, msb first, one byte
  function automatic logic [CRC_W-1:0] crc_step(input logic [CRC_W-1:0] crc_in,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < BYTE_W; i++) begin
      c = c[CRC_W-1] ? ({c[CRC_W-2:0], 1'b0} ^ CRC_POLY) : {c[CRC_W-2:0], 1'b0};
    end
    return c;
  endfunction

endpackage
`default_nettype wire

>>> rtl/cfr_channels.sv
`default_nettype none
interface cfr_rx_if;
  import cfr_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface cfr_res_if;
  import cfr_pkg::*;
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   out_kind;
  logic [BYTE_W-1:0]   out_byte;
  logic [LEN_W-1:0]    seek_position;
  logic [STATUS_W-1:0] transfer_status;
  logic                last;
  modport source (output valid, output out_kind, output out_byte, output seek_position,
                  output transfer_status, output last, input ready);
  modport sink (input valid, input out_kind, input out_byte, input seek_position,
                input transfer_status, input last, output ready);
endinterface
`default_nettype wire

>>> rtl/chunked_file_receiver_crc16.sv
`default_nettype none
// channel   dir  payload                                                  transaction
// rx        in   rx_byte                                                  one received byte
// result    out  out_kind, out_byte, seek_position, transfer_status, last one result
// apb       in   psel/penable/pwrite/paddr/pwdata -> prdata, pready        max_chunk_length
//
// a byte enters an input register, then combinational decode/crc logic turns it into
// a bundle of zero to three results in the result register
// a byte with several results holds the result register until its last result leaves,
// and the next byte waits in the input register
// rst is synchronous: phase returns to waiting for the file length, counters clear,
// max_chunk_length returns to 8192; no clearing pass
// result.ready low only stalls the result register; one more byte is still taken
module chunked_file_receiver_crc16 (
  input  wire                    clk,
  input  wire                    rst,
  cfr_rx_if.sink                 rx,
  cfr_res_if.source              result,
  input  wire                    psel,
  input  wire                    penable,
  input  wire                    pwrite,
  input  wire  [2:0]             paddr,
  input  wire  [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  import cfr_pkg::*;

  // configuration register
  logic [CHUNK_W-1:0] max_chunk_length;

  // input register
  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;

  // protocol state
  phase_t             phase, phase_next;
  logic [1:0]         field_byte_count, field_byte_count_next;
  logic [LEN_W-1:0]   file_length, file_length_next;
  logic [LEN_W-1:0]   bytes_accepted, bytes_accepted_next;
  logic [CHUNK_W-1:0] chunk_length, chunk_length_next;
  logic [CHUNK_W-1:0] chunk_remaining, chunk_remaining_next;
  logic [CRC_W-1:0]   expected_crc, expected_crc_next;
  logic [CRC_W-1:0]   running_crc, running_crc_next;
  logic [LEN_W-1:0]   field_accumulator, field_accumulator_next;

  // result register: up to three pending results, head in slot 0
  result_t    res_q [SLOTS];
  logic [1:0] res_cnt;
  result_t    res_new [SLOTS];
  logic [1:0] new_cnt;

  logic res_fire;
  logic bundle_free;
  logic process;

  // per-byte datapath terms
  logic [LEN_W-1:0]   acc_shift;
  logic [1:0]         cnt_inc;
  logic [CRC_W-1:0]   crc_upd;
  logic [CHUNK_W-1:0] rem_dec;
  logic               fin;
  logic [CRC_W-1:0]   fin_crc;
  logic [CRC_W-1:0]   fin_exp;
  logic               crc_match;
  logic [LEN_W-1:0]   acc_sum;

  // ---------------------------------------------------------------- apb
  assign pready = 1'b1;

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_MAX_CHUNK) begin
      prdata = {16'd0, max_chunk_length};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_chunk_length <= MAX_CHUNK_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_MAX_CHUNK) begin
      max_chunk_length <= pwdata[CHUNK_W-1:0];
    end
  end

  // ---------------------------------------------------------------- handshakes
  assign res_fire    = result.valid && result.ready;
  // the bundle can be replaced once its last result leaves this cycle
  assign bundle_free = (res_cnt == 2'd0) || (res_cnt == 2'd1 && res_fire);
  assign process     = in_valid && bundle_free;
  assign rx.ready    = !in_valid || process;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.ready) begin
      in_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      in_byte <= rx.rx_byte;
    end
  end

  // ---------------------------------------------------------------- decode
  always_comb begin
    phase_next             = phase;
    field_byte_count_next  = field_byte_count;
    file_length_next       = file_length;
    bytes_accepted_next    = bytes_accepted;
    chunk_length_next      = chunk_length;
    chunk_remaining_next   = chunk_remaining;
    expected_crc_next      = expected_crc;
    running_crc_next       = running_crc;
    field_accumulator_next = field_accumulator;

    for (int i = 0; i < SLOTS; i++) begin
      res_new[i] = '0;
    end
    new_cnt = 2'd0;

    acc_shift = {field_accumulator[LEN_W-BYTE_W-1:0], in_byte};
    cnt_inc   = field_byte_count + 2'd1;
    crc_upd   = crc_step(running_crc, in_byte);
    rem_dec   = chunk_remaining - 16'd1;
    fin       = 1'b0;
    fin_crc   = running_crc;
    fin_exp   = expected_crc;
    crc_match = 1'b0;
    acc_sum   = bytes_accepted;

    case (phase)
      PH_CMD: begin
        field_byte_count_next  = 2'd0;
        field_accumulator_next = '0;
        if (in_byte == CH_CHUNK) begin
          phase_next = PH_CLEN;
        end else if (in_byte == CH_SEEK) begin
          phase_next = PH_SEEK;
        end else if (in_byte == CH_MINUS) begin
          res_new[0] = mk_result(K_STATUS, '0, '0, ST_ABORTED);
          new_cnt    = 2'd1;
          phase_next = PH_LEN;
        end else begin
          res_new[0] = mk_result(K_STATUS, '0, '0, ST_BAD_CMD);
          new_cnt    = 2'd1;
          phase_next = PH_LEN;
        end
      end
      PH_CLEN: begin
        field_byte_count_next  = cnt_inc;
        field_accumulator_next = acc_shift;
        if (cnt_inc == 2'd2) begin
          field_byte_count_next  = 2'd0;
          field_accumulator_next = '0;
          chunk_length_next      = acc_shift[CHUNK_W-1:0];
          if (acc_shift[CHUNK_W-1:0] > max_chunk_length) begin
            res_new[0] = mk_result(K_REPLY, CH_MINUS, '0, ST_TOO_LONG);
            new_cnt    = 2'd1;
            phase_next = PH_LEN;
          end else begin
            phase_next = PH_CCRC;
          end
        end
      end
      PH_CCRC: begin
        field_byte_count_next  = cnt_inc;
        field_accumulator_next = acc_shift;
        if (cnt_inc == 2'd2) begin
          field_byte_count_next  = 2'd0;
          field_accumulator_next = '0;
          expected_crc_next      = acc_shift[CRC_W-1:0];
          running_crc_next       = '0;
          chunk_remaining_next   = chunk_length;
          if (chunk_length == '0) begin
            // empty chunk: crc of nothing is zero
            fin     = 1'b1;
            fin_crc = '0;
            fin_exp = acc_shift[CRC_W-1:0];
          end else begin
            phase_next = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        res_new[0]           = mk_result(K_DATA, in_byte, '0, ST_RUNNING);
        new_cnt              = 2'd1;
        running_crc_next     = crc_upd;
        chunk_remaining_next = rem_dec;
        if (rem_dec == '0) begin
          fin     = 1'b1;
          fin_crc = crc_upd;
          fin_exp = expected_crc;
        end
      end
      PH_SEEK: begin
        field_byte_count_next  = cnt_inc;
        field_accumulator_next = acc_shift;
        if (cnt_inc == 2'd0) begin
          res_new[0]             = mk_result(K_SEEK, '0, acc_shift, ST_RUNNING);
          res_new[1]             = mk_result(K_REPLY, CH_PLUS, '0, ST_RUNNING);
          new_cnt                = 2'd2;
          field_byte_count_next  = 2'd0;
          field_accumulator_next = '0;
          phase_next             = PH_CMD;
        end
      end
      default: begin
        // waiting for the 4-byte file length
        phase_next             = PH_LEN;
        field_byte_count_next  = cnt_inc;
        field_accumulator_next = acc_shift;
        if (cnt_inc == 2'd0) begin
          field_byte_count_next  = 2'd0;
          field_accumulator_next = '0;
          file_length_next       = acc_shift;
          bytes_accepted_next    = '0;
          if (acc_shift == '0) begin
            res_new[0] = mk_result(K_REPLY, CH_DONE, '0, ST_COMPLETED);
            new_cnt    = 2'd1;
          end else begin
            phase_next = PH_CMD;
          end
        end
      end
    endcase

    // end of chunk: reply, count on a match, then completion check
    if (fin) begin
      crc_match = (fin_crc == fin_exp);
      if (crc_match) begin
        res_new[new_cnt] = mk_result(K_REPLY, CH_PLUS, '0, ST_RUNNING);
        acc_sum          = bytes_accepted + {16'd0, chunk_length};
      end else begin
        res_new[new_cnt] = mk_result(K_REPLY, CH_MINUS, '0, ST_CRC_ERR);
      end
      new_cnt             = new_cnt + 2'd1;
      bytes_accepted_next = acc_sum;
      if (acc_sum >= file_length) begin
        res_new[new_cnt]       = mk_result(K_REPLY, CH_DONE, '0, ST_COMPLETED);
        new_cnt                = new_cnt + 2'd1;
        phase_next             = PH_LEN;
        field_byte_count_next  = 2'd0;
        field_accumulator_next = '0;
      end else begin
        phase_next = PH_CMD;
      end
    end
  end

  // ---------------------------------------------------------------- state register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_LEN;
      field_byte_count  <= '0;
      file_length       <= '0;
      bytes_accepted    <= '0;
      chunk_length      <= '0;
      chunk_remaining   <= '0;
      expected_crc      <= '0;
      running_crc       <= '0;
      field_accumulator <= '0;
    end else if (process) begin
      phase             <= phase_next;
      field_byte_count  <= field_byte_count_next;
      file_length       <= file_length_next;
      bytes_accepted    <= bytes_accepted_next;
      chunk_length      <= chunk_length_next;
      chunk_remaining   <= chunk_remaining_next;
      expected_crc      <= expected_crc_next;
      running_crc       <= running_crc_next;
      field_accumulator <= field_accumulator_next;
    end
  end

  // ---------------------------------------------------------------- result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_cnt <= 2'd0;
    end else if (process) begin
      res_cnt <= new_cnt;
    end else if (res_fire) begin
      res_cnt <= res_cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      res_q <= res_new;
    end else if (res_fire) begin
      // pop the head
      res_q[0] <= res_q[1];
      res_q[1] <= res_q[2];
    end
  end

  assign result.valid           = (res_cnt != 2'd0);
  assign result.out_kind        = res_q[0].kind;
  assign result.out_byte        = res_q[0].data;
  assign result.seek_position   = res_q[0].seek;
  assign result.transfer_status = res_q[0].status;
  assign result.last            = (res_cnt == 2'd1);

  // ---------------------------------------------------------------- assertions
  // a new bundle never overwrites results that are still pending
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    process |-> (res_cnt == 2'd0 || (res_cnt == 2'd1 && res_fire)))
    else $error("result bundle overwritten while pending");

  // a held byte in the input register is not dropped
  a_input_held: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !process) |=> in_valid)
    else $error("input byte lost while stalled");

  // a seek request is always followed by its '+' reply in the same bundle
  a_seek_reply: assert property (@(posedge clk) disable iff (rst)
    (result.valid && res_q[0].kind == K_SEEK) |->
      (res_cnt == 2'd2 && res_q[1].kind == K_REPLY && res_q[1].data == CH_PLUS))
    else $error("seek request without reply");

  // popping a two-result bundle leaves one result
  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    (res_fire && !process && res_cnt == 2'd2) |=> res_cnt == 2'd1)
    else $error("result count wrong after pop");

endmodule
`default_nettype wire

>>> tb/sv/tb_top.sv
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cfr_pkg::*;

  // byte address of the max chunk length register
  localparam logic [2:0] MAX_CHUNK_ADDR = {REG_MAX_CHUNK, 2'b00};

  // one result as seen on the result channel
  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [BYTE_W-1:0]   data;
    logic [LEN_W-1:0]    seek;
    logic [STATUS_W-1:0] status;
    logic                last;
  } outcome_t;

  // protocol state of the receiver, kept twice: once for the bytes already
  // accepted by the block, once for the bytes the generator has queued
  typedef struct packed {
    phase_t             ph;
    logic [1:0]         fcnt;      // bytes gathered into the current field
    logic [LEN_W-1:0]   acc;       // field shift register
    logic [LEN_W-1:0]   flen;      // announced file length
    logic [LEN_W-1:0]   got_bytes; // bytes of chunks that passed their crc
    logic [CHUNK_W-1:0] clen;
    logic [CHUNK_W-1:0] cleft;
    logic [CRC_W-1:0]   crc_want;
    logic [CRC_W-1:0]   crc_run;
  } xfer_state_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  cfr_rx_if  rx_ch ();
  cfr_res_if res_ch ();

  chunked_file_receiver_crc16 DUT (
    .clk     (clk),
    .rst     (rst),
    .rx      (rx_ch),
    .result  (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // bytes queued for the link, front one is the one on the wire
  logic [BYTE_W-1:0] link_bytes[$];
  // results the block still owes, oldest first
  outcome_t          awaited_outputs[$];

  xfer_state_t        live_st;
  xfer_state_t        plan_st;
  logic [CHUNK_W-1:0] chunk_cap;

  int  send_idle_pct;
  int  recv_idle_pct;
  bit  rx_taken;
  int  stall_left;
  int  next_stall_at = 40;
  int  bytes_planned;
  int  bytes_sent;
  int  results_seen;
  int  transfers_done;
  int  crc_rejects;
  int  seeks_seen;
  int  cap_writes;
  int  errors;

  outcome_t seen_out;
  outcome_t due_out;

  // crc-16 ccitt, msb first, zero start, one bit per step
  function automatic logic [CRC_W-1:0] crc16_next(input logic [CRC_W-1:0] c,
                                                   input logic [BYTE_W-1:0] d);
    logic fb;
    for (int i = BYTE_W - 1; i >= 0; i--) begin
      fb = c[CRC_W-1] ^ d[i];
      c = {c[CRC_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
    end
    return c;
  endfunction

  function automatic outcome_t make_outcome(input logic [KIND_W-1:0] k,
                                            input logic [BYTE_W-1:0] d,
                                            input logic [LEN_W-1:0] sk,
                                            input logic [STATUS_W-1:0] st);
    outcome_t o;
    o.kind   = k;
    o.data   = d;
    o.seek   = sk;
    o.status = st;
    o.last   = 1'b0;
    return o;
  endfunction

  // shift one byte into a big-endian field; need is the field size mod 4
  task automatic gather(inout xfer_state_t s, input logic [BYTE_W-1:0] b,
                        input logic [1:0] need, output bit full);
    s.acc  = {s.acc[LEN_W-9:0], b};
    s.fcnt = s.fcnt + 2'd1;
    full   = (s.fcnt == need);
    if (full) begin
      s.fcnt = 2'd0;
    end
  endtask

  // one received byte through the protocol; with record set the results it
  // causes are queued as owed by the block
  task automatic receiver_step(inout xfer_state_t s, input logic [BYTE_W-1:0] b,
                               input bit record);
    outcome_t outs[3];
    int       n;
    bit       full;
    bit       close_chunk;
    bit       check_end;
    n = 0;
    full = 0;
    close_chunk = 0;
    check_end = 0;
    case (s.ph)
      PH_CMD: begin
        s.fcnt = 2'd0;
        s.acc  = '0;
        if (b == CH_CHUNK) begin
          s.ph = PH_CLEN;
        end else if (b == CH_SEEK) begin
          s.ph = PH_SEEK;
        end else begin
          // sender abort or unknown command, both end the transfer
          outs[n] = make_outcome(K_STATUS, 8'h00, '0,
                                 (b == CH_MINUS) ? ST_ABORTED : ST_BAD_CMD);
          n++;
          s.ph = PH_LEN;
        end
      end
      PH_CLEN: begin
        gather(s, b, 2'd2, full);
        if (full) begin
          s.clen = s.acc[CHUNK_W-1:0];
          s.acc  = '0;
          if (s.clen > chunk_cap) begin
            outs[n] = make_outcome(K_REPLY, CH_MINUS, '0, ST_TOO_LONG);
            n++;
            s.ph = PH_LEN;
          end else begin
            s.ph = PH_CCRC;
          end
        end
      end
      PH_CCRC: begin
        gather(s, b, 2'd2, full);
        if (full) begin
          s.crc_want = s.acc[CRC_W-1:0];
          s.acc      = '0;
          s.crc_run  = '0;
          s.cleft    = s.clen;
          if (s.clen == 0) begin
            close_chunk = 1;
          end else begin
            s.ph = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        outs[n] = make_outcome(K_DATA, b, '0, ST_RUNNING);
        n++;
        s.crc_run = crc16_next(s.crc_run, b);
        s.cleft   = s.cleft - 1'b1;
        if (s.cleft == 0) begin
          close_chunk = 1;
        end
      end
      PH_SEEK: begin
        gather(s, b, 2'd0, full);
        if (full) begin
          outs[n] = make_outcome(K_SEEK, 8'h00, s.acc, ST_RUNNING);
          n++;
          outs[n] = make_outcome(K_REPLY, CH_PLUS, '0, ST_RUNNING);
          n++;
          s.acc = '0;
          s.ph  = PH_CMD;
        end
      end
      default: begin
        s.ph = PH_LEN;
        gather(s, b, 2'd0, full);
        if (full) begin
          s.flen      = s.acc;
          s.acc       = '0;
          s.got_bytes = '0;
          check_end   = 1;
        end
      end
    endcase
    // reply to a finished chunk; only a good crc counts its bytes
    if (close_chunk) begin
      if (s.crc_run == s.crc_want) begin
        outs[n] = make_outcome(K_REPLY, CH_PLUS, '0, ST_RUNNING);
        s.got_bytes = s.got_bytes + s.clen;
      end else begin
        outs[n] = make_outcome(K_REPLY, CH_MINUS, '0, ST_CRC_ERR);
      end
      n++;
      check_end = 1;
    end
    if (check_end) begin
      if (s.got_bytes >= s.flen) begin
        outs[n] = make_outcome(K_REPLY, CH_DONE, '0, ST_COMPLETED);
        n++;
        s.ph   = PH_LEN;
        s.fcnt = 2'd0;
        s.acc  = '0;
      end else begin
        s.ph = PH_CMD;
      end
    end
    if (record && n > 0) begin
      outs[n-1].last = 1'b1;
      for (int i = 0; i < n; i++) begin
        awaited_outputs.push_back(outs[i]);
      end
    end
  endtask

  // queue a byte for the link and advance the planning copy of the state
  task automatic push_byte(input logic [BYTE_W-1:0] b);
    link_bytes.push_back(b);
    receiver_step(plan_st, b, 1'b0);
    bytes_planned++;
  endtask

  task automatic push_word(input logic [LEN_W-1:0] v, input int nbytes);
    for (int i = nbytes - 1; i >= 0; i--) begin
      push_byte(v[8*i +: 8]);
    end
  endtask

  // chunk command with random payload; bad_crc flips the announced crc
  task automatic push_chunk(input bit bad_crc);
    logic [BYTE_W-1:0]  body[$];
    logic [CHUNK_W-1:0] len;
    logic [CHUNK_W-1:0] lim;
    logic [CRC_W-1:0]   crc;
    lim = (chunk_cap < 12) ? chunk_cap : 16'd12;
    // now and then a longer chunk, bounded to keep the run short
    if ($urandom_range(0, 24) == 0) begin
      lim = (chunk_cap < 200) ? chunk_cap : 16'd200;
    end
    len = $urandom_range(0, lim);
    crc = '0;
    for (int i = 0; i < len; i++) begin
      body.push_back($urandom_range(0, 255));
      crc = crc16_next(crc, body[i]);
    end
    if (bad_crc) begin
      crc = crc ^ $urandom_range(1, 16'hFFFF);
    end
    push_byte(CH_CHUNK);
    push_word(len, 2);
    push_word(crc, 2);
    foreach (body[i]) begin
      push_byte(body[i]);
    end
  endtask

  // picks the next piece of stimulus from where the planned state stands
  task automatic plan_segment();
    int                pick;
    logic [BYTE_W-1:0] b;
    logic [LEN_W-1:0]  flen;
    pick = $urandom_range(0, 99);
    if (plan_st.ph == PH_CMD) begin
      if (pick < 55) begin
        push_chunk(1'b0);
      end else if (pick < 65) begin
        push_chunk(1'b1);
      end else if (pick < 77) begin
        push_byte(CH_SEEK);
        push_word($urandom, 4);
      end else if (pick < 82) begin
        push_byte(CH_MINUS);
      end else if (pick < 92 && !(pick >= 87 && chunk_cap != 16'hFFFF)) begin
        // unknown command byte
        do begin
          b = $urandom_range(0, 255);
        end while (b == CH_CHUNK || b == CH_SEEK || b == CH_MINUS);
        push_byte(b);
      end else if (pick < 92) begin
        // announced length just past the limit or anywhere above it
        push_byte(CH_CHUNK);
        push_word(($urandom_range(0, 1) == 0) ? chunk_cap + 1'b1
                  : $urandom_range(chunk_cap + 1, 16'hFFFF), 2);
      end else begin
        // noise in place of a command, anything but a chunk start
        do begin
          b = $urandom_range(0, 255);
        end while (b == CH_CHUNK);
        push_byte(b);
      end
    end else if (plan_st.ph == PH_LEN && plan_st.fcnt == 0) begin
      if (pick < 8) begin
        // partial length field of noise, finished by later segments
        repeat ($urandom_range(1, 3)) push_byte($urandom_range(0, 255));
      end else begin
        if (pick < 13) begin
          flen = $urandom;
        end else if (pick < 20) begin
          flen = '0;
        end else begin
          flen = $urandom_range(1, 48);
        end
        push_word(flen, 4);
      end
    end else begin
      // inside a field left open by noise
      push_byte($urandom_range(0, 255));
    end
  endtask

  task automatic plan_random(input int count);
    int target;
    target = bytes_planned + count;
    while (bytes_planned < target) begin
      plan_segment();
    end
  endtask

  // wait until every queued byte went in and every owed result came out,
  // then wait on for bytes that cause no result
  task automatic settle();
    while (link_bytes.size() != 0 || awaited_outputs.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
  endtask

  // register write, then a read back of the same register
  task automatic write_cap(input logic [CHUNK_W-1:0] v);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MAX_CHUNK_ADDR;
    pwdata  <= {16'h0000, v};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    chunk_cap = v;
    cap_writes++;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {16'h0000, v}) begin
      $display("%0t: max_chunk_length read back: expected %h, got %h", $time,
               {16'h0000, v}, prdata);
      errors++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // clock, and known values on every input from time zero
  initial begin
    clk           = 1'b0;
    rst           = 1'b1;
    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = '0;
    res_ch.ready  = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    forever #5 clk = ~clk;
  end

  // link byte transaction: predict at the edge that accepts it
  always @(posedge clk) begin
    if (rst) begin
      rx_taken <= 1'b0;
    end else begin
      rx_taken <= rx_ch.valid && rx_ch.ready;
      if (rx_ch.valid && rx_ch.ready) begin
        receiver_step(live_st, rx_ch.rx_byte, 1'b1);
        void'(link_bytes.pop_front());
        bytes_sent++;
      end
    end
  end

  // sender: a byte once offered stays on the wire until taken
  always @(negedge clk) begin
    if (rst) begin
      rx_ch.valid <= 1'b0;
    end else if (!(rx_ch.valid && !rx_taken)) begin
      if (link_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= link_bytes[0];
      end else begin
        rx_ch.valid <= 1'b0;
      end
    end
  end

  // receiver: random ready, plus a long hold after 40 results and every 220 after that so
  // the block backs up and stops taking bytes
  always @(negedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      res_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (results_seen >= next_stall_at) begin
      res_ch.ready  <= 1'b0;
      stall_left    <= 80;
      next_stall_at <= next_stall_at + 220;
    end else begin
      res_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // result transaction: compare against the oldest owed result
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      seen_out.kind   = res_ch.out_kind;
      seen_out.data   = res_ch.out_byte;
      seen_out.seek   = res_ch.seek_position;
      seen_out.status = res_ch.transfer_status;
      seen_out.last   = res_ch.last;
      results_seen++;
      if (awaited_outputs.size() == 0) begin
        $display("%0t: result with none expected: got kind %0d byte %h seek %h status %0d last %0d",
                 $time, seen_out.kind, seen_out.data, seen_out.seek, seen_out.status,
                 seen_out.last);
        errors++;
      end else begin
        due_out = awaited_outputs.pop_front();
        if (seen_out !== due_out) begin
          $display("%0t: result mismatch: expected kind %0d byte %h seek %h status %0d last %0d",
                   $time, due_out.kind, due_out.data, due_out.seek, due_out.status,
                   due_out.last);
          $display("%0t:                  got kind %0d byte %h seek %h status %0d last %0d",
                   $time, seen_out.kind, seen_out.data, seen_out.seek, seen_out.status,
                   seen_out.last);
          errors++;
        end
      end
      if (seen_out.status == ST_COMPLETED) transfers_done++;
      if (seen_out.status == ST_CRC_ERR) crc_rejects++;
      if (seen_out.kind == K_SEEK) seeks_seen++;
    end
  end

  // stimulus and phases
  initial begin
    logic [BYTE_W-1:0] opening[$];
    live_st       = '0;  // phase code zero waits for the file length
    plan_st       = '0;
    chunk_cap     = MAX_CHUNK_RESET;
    send_idle_pct = 27;
    recv_idle_pct = 76;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty file; then a one-byte file with a seek to the top offset, an
    // empty chunk, a chunk failing its crc, a chunk over the limit; then a
    // transfer the sender aborts
    opening = {8'h00, 8'h00, 8'h00, 8'h00,
               8'h00, 8'h00, 8'h00, 8'h01,
               CH_SEEK, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
               CH_CHUNK, 8'h00, 8'h00, 8'h00, 8'h00,
               CH_CHUNK, 8'h00, 8'h01, 8'h00, 8'h00, 8'hFF,
               CH_CHUNK, 8'hFF, 8'hFF,
               8'h00, 8'h00, 8'h00, 8'h01,
               CH_MINUS};
    foreach (opening[i]) begin
      push_byte(opening[i]);
    end
    plan_random(130);

    // only empty chunks fit
    settle();
    write_cap('0);
    plan_random(35);

    // idling swaps sides; no length is too long
    settle();
    send_idle_pct = 76;
    recv_idle_pct = 27;
    write_cap(16'hFFFF);
    plan_random(100);

    settle();
    write_cap(16'd6);
    plan_random(50);

    // back to back on both sides
    settle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_cap($urandom_range(1, 40));
    plan_random(85);

    settle();
    repeat (12) @(posedge clk);
    $display("sent %0d link bytes: %0d transfers completed, %0d chunks failed crc, %0d seeks",
             bytes_sent, transfers_done, crc_rejects, seeks_seen);
    $display("checked %0d results over %0d chunk limit settings, 0 and 65535 among them",
             results_seen, cap_writes);
    if (errors == 0) begin
      $display("chunked_file_receiver_crc16: match");
    end else begin
      $display("chunked_file_receiver_crc16: mismatch");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("timeout with %0d results still owed", awaited_outputs.size());
    $display("chunked_file_receiver_crc16: mismatch");
    $finish;
  end

endmodule
`default_nettype wire
